// ----- hw/rtl/mf3_pkg.sv -----
// mf3_pkg: shared constants, types and the compare-exchange network of the
// 3x3 median filter. No dependencies.

package mf3_pkg;

  // pixel and geometry
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned PIXEL_BITS = 16;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 12;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned OUT_COL_W  = 10;
  localparam int unsigned RAM_W      = 2 * PIX_W;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
  localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
  localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
  localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);

  // register file
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  localparam pix_t PIX_MASK = pix_t'((64'd1 << PIXEL_BITS) - 64'd1);

  // neighbourhood: 0..2 column c-2, 3..5 column c-1, 6..8 current column
  localparam int unsigned NB        = 9;
  localparam int unsigned NET_PAIRS = 19;
  localparam int unsigned NET_CUT1  = 9;
  localparam int unsigned NET_CUT2  = 16;

  typedef pix_t [NB-1:0] pix9_t;
  typedef logic [3:0] nb_idx_t;

  localparam nb_idx_t NET_LO [NET_PAIRS] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7,
    4'd0, 4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam nb_idx_t NET_HI [NET_PAIRS] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8,
    4'd3, 4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };
  localparam int unsigned MED_IDX = 4;

  // apply the network pairs lo .. hi-1 in order
  function automatic pix9_t net_pass(input pix9_t p_in, input int unsigned lo,
                                     input int unsigned hi);
    pix9_t p;
    pix_t  t;
    p = p_in;
    for (int unsigned i = 0; i < NET_PAIRS; i++) begin
      if (i >= lo && i < hi && p[NET_LO[i]] > p[NET_HI[i]]) begin
        t            = p[NET_LO[i]];
        p[NET_LO[i]] = p[NET_HI[i]];
        p[NET_HI[i]] = t;
      end
    end
    return p;
  endfunction

endpackage

// ----- hw/rtl/mf3_if.sv -----
// mf3_if: valid/ready stream interfaces for pixel words and result words.
// Depends on mf3_pkg.

interface mf3_pix_if import mf3_pkg::*; ();
  logic valid;
  logic ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface mf3_res_if import mf3_pkg::*; ();
  logic valid;
  logic ready;
  logic [PIX_W-1:0]     pixel_out;
  logic [ROW_W-1:0]     out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 last_of_frame;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input last_of_frame, output ready);
endinterface

// ----- hw/rtl/mf3_ram.sv -----
// mf3_ram: generic simple dual-port RAM, one write and one registered read
// port. No dependencies.

module mf3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/mf3_sort.sv -----
// mf3_sort: pipelined 19-pair compare-exchange network giving the median of
// nine pixels, three compare levels per stage. Depends on mf3_pkg.

module mf3_sort import mf3_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  pix9_t nb_i,
  output pix_t  med_o
);

  pix9_t q1_r;
  pix9_t q2_r;
  pix9_t q_fin;

  // first and second sections of the network, registered
  always_ff @(posedge clk) begin
    if (en) begin
      q1_r <= net_pass(nb_i, 0, NET_CUT1);
      q2_r <= net_pass(q1_r, NET_CUT1, NET_CUT2);
    end
  end

  // last three pairs only touch the middle, result left unregistered
  always_comb begin
    q_fin = net_pass(q2_r, NET_CUT2, NET_PAIRS);
    med_o = q_fin[MED_IDX];
  end

endmodule

// ----- hw/rtl/median_filter_3x3_core.sv -----
// median_filter_3x3_core: streaming 3x3 median filter top level.
// Depends on mf3_pkg, mf3_if, mf3_ram and mf3_sort.
//
//   channel  dir  kind         payload
//   in_ch    in   valid/ready  pixel_in
//   out_ch   out  valid/ready  pixel_out, out_row, out_col, last_of_frame
//   psel..   in   APB          frame_width at 0x0, frame_height at 0x4
//
// One pixel word accepted per cycle while the output is not stalled. A word that
// releases k results holds the output register until all k are taken (two at a
// row end, up to three on the last row), and input waits meanwhile; the output
// sequencer sets this. The first result of a word passes the line store read,
// two network stages, then the output register.
// rst_n is synchronous: it clears the pipeline, counters, window and
// registers; the line store is not cleared. A stalled output freezes the
// whole pipeline, including the line store read data.

module median_filter_3x3_core import mf3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mf3_pix_if.sink           in_ch,
  mf3_res_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef struct packed {
    logic emit_a;
    logic emit_b;
    logic emit_c;
    logic interior;
    logic last;
  } flags_t;

  typedef struct packed {
    pix_t              pix;
    pix_t              above;
    pix_t              border;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] col;
    flags_t            fl;
  } meta_t;

  // configuration
  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;
  logic            cfg_wr;

  // position counters
  logic [ROW_W-1:0]  row_r, row_nxt, row_use;
  logic [ADDR_W-1:0] col_r, col_nxt, col_use;
  logic [FW_W:0]     col_inc;
  logic [ROW_W:0]    row_inc;
  flags_t            fl0;

  // pipeline
  logic              adv;
  logic              acc;
  logic              v1_r, v2_r, v3_r;
  pix_t              pix1_r;
  logic [ROW_W-1:0]  row1_r;
  logic [ADDR_W-1:0] col1_r;
  flags_t            fl1_r;
  logic [RAM_W-1:0]  ram_rd;
  pix_t              older, prev;
  pix_t [5:0]        win_r;
  pix9_t             nb;
  meta_t             m1, m2_r, m3_r;
  pix_t              med;

  // output holder
  meta_t       h_r;
  pix_t        h_a_r;
  logic [2:0]  pend_r;
  logic        take;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  fw_r <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = APB_DW'(fw_r);
      REG_FRAME_HEIGHT: prdata = APB_DW'(fh_r);
      default:          prdata = '0;
    endcase
  end

  // effective frame size
  always_comb begin
    if (fw_r < FW_MIN)      w_eff = FW_MIN;
    else if (fw_r > FW_MAX) w_eff = FW_MAX;
    else                    w_eff = fw_r;
    h_eff = (fh_r < FH_MIN) ? FH_MIN : fh_r;
  end

  // pipeline advance: output holder empty or its last result leaving
  assign take = out_ch.valid && out_ch.ready;
  assign adv  = (pend_r == 3'b000) || (take && ((pend_r & (pend_r - 3'd1)) == 3'b000));
  assign in_ch.ready = adv;
  assign acc  = in_ch.valid && adv;

  // position of the incoming word and result flags
  always_comb begin
    col_use = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
    row_use = (row_r >= h_eff) ? '0 : row_r;
    fl0.last     = ({1'b0, col_use} == (w_eff - FW_W'(1)));
    fl0.emit_a   = (row_use != '0) && (col_use != '0);
    fl0.interior = (row_use >= ROW_W'(2)) && (col_use >= ADDR_W'(2));
    fl0.emit_b   = fl0.emit_a && fl0.last;
    fl0.emit_c   = (row_use == (h_eff - FH_W'(1)));
    col_inc = {1'b0, FW_W'(col_use)} + (FW_W+1)'(1);
    row_inc = {1'b0, row_use} + (ROW_W+1)'(1);
    col_nxt = col_inc[ADDR_W-1:0];
    row_nxt = row_use;
    if (col_inc >= {1'b0, w_eff}) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_wr) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // line store: entry holds {row two above, row above}
  mf3_ram #(.WIDTH(RAM_W), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (adv && v1_r),
    .waddr (col1_r),
    .wdata ({prev, pix1_r}),
    .re    (acc),
    .raddr (col_use),
    .rdata (ram_rd)
  );

  assign older = ram_rd[RAM_W-1:PIX_W];
  assign prev  = ram_rd[PIX_W-1:0];

  // stage 1: word waiting for its line store column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pix1_r <= pix_t'(in_ch.pixel_in) & PIX_MASK;
      row1_r <= row_use;
      col1_r <= col_use;
      fl1_r  <= fl0;
    end
  end

  // window of the two previous columns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (adv && v1_r) begin
      win_r[2:0] <= win_r[5:3];
      win_r[3]   <= older;
      win_r[4]   <= prev;
      win_r[5]   <= pix1_r;
    end
  end

  // neighbourhood and side data of stage 1
  always_comb begin
    nb[5:0] = win_r;
    nb[6]   = older;
    nb[7]   = prev;
    nb[8]   = pix1_r;
    m1.pix    = pix1_r;
    m1.above  = prev;
    m1.border = win_r[4];
    m1.row    = row1_r;
    m1.col    = col1_r;
    m1.fl     = fl1_r;
  end

  mf3_sort u_sort (
    .clk   (clk),
    .en    (adv),
    .nb_i  (nb),
    .med_o (med)
  );

  // side data travelling alongside the network
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r <= m1;
      m3_r <= m2_r;
    end
  end

  // output holder: pending results, lowest bit first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'b000;
    end else if (adv) begin
      pend_r <= v3_r ? {m3_r.fl.emit_c, m3_r.fl.emit_b, m3_r.fl.emit_a} : 3'b000;
    end else if (take) begin
      pend_r <= pend_r & (pend_r - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_r   <= m3_r;
      h_a_r <= m3_r.fl.interior ? med : m3_r.border;
    end
  end

  // result word select
  always_comb begin
    out_ch.valid         = (pend_r != 3'b000);
    out_ch.last_of_frame = 1'b0;
    if (pend_r[0]) begin
      out_ch.pixel_out = h_a_r;
      out_ch.out_row   = h_r.row - ROW_W'(1);
      out_ch.out_col   = OUT_COL_W'(h_r.col - ADDR_W'(1));
    end else if (pend_r[1]) begin
      out_ch.pixel_out = h_r.above;
      out_ch.out_row   = h_r.row - ROW_W'(1);
      out_ch.out_col   = OUT_COL_W'(h_r.col);
    end else begin
      out_ch.pixel_out     = h_r.pix;
      out_ch.out_row       = h_r.row;
      out_ch.out_col       = OUT_COL_W'(h_r.col);
      out_ch.last_of_frame = h_r.fl.last;
    end
  end

endmodule
